### hdl/esar_pkg.sv
`default_nettype none
package esar_pkg;

    // build defaults
    localparam int NUM_SLOTS_DEF  = 6;
    localparam int FIFO_DEPTH_DEF = 4;

    // fixed field widths
    localparam int MAX_SLOTS  = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;
    localparam int ROM_SIZE_W = 25;
    localparam int ROM_IDX_W  = 24;
    localparam int OFFSET_W   = 28;
    localparam int SLOT_W     = 4;

    typedef enum logic [2:0] {
        TGT_OPEN_BUS   = 3'd0,
        TGT_DEV_READ   = 3'd1,
        TGT_DEV_WRITE  = 3'd2,
        TGT_ROM_READ   = 3'd3,
        TGT_WRITE_DROP = 3'd4
    } t_target;

    // one queued bus access; data is left-aligned, cnt is byte count minus one
    typedef struct packed {
        logic        wr;
        logic [31:0] addr;
        logic [1:0]  cnt;
        logic [31:0] data;
    } t_access;

    // one byte in flight through the ROM index pipeline
    typedef struct packed {
        t_target                 target;
        logic [SLOT_W-1:0]       slot;
        logic [OFFSET_W-1:0]     offset;
        logic [7:0]              byte_data;
        logic                    last;
        logic [ROM_SIZE_W-1:0]   rom_size;
        logic [ROM_IDX_W-1:0]    dvd;
        logic [ROM_IDX_W-1:0]    rem;
    } t_byte;

    typedef struct packed {
        t_target                 target;
        logic [SLOT_W-1:0]       slot;
        logic [OFFSET_W-1:0]     offset;
        logic [ROM_IDX_W-1:0]    rom_index;
        logic [7:0]              byte_data;
        logic                    last;
    } t_result;

    typedef struct packed {
        logic                    we;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
    } t_cfg_wr;

endpackage
`default_nettype wire

### hdl/esar_front.sv
`default_nettype none
module esar_front (
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [31:0]       i_address,
    input  logic [1:0]        i_access_size,
    input  logic [31:0]       i_write_data,
    input  logic              i_full,
    output logic              o_push,
    output esar_pkg::t_access o_entry
);
    import esar_pkg::*;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // big-endian: first byte out sits in the top byte of data
    always_comb begin
        o_entry.wr   = i_op;
        o_entry.addr = i_address;
        case (i_access_size)
            SZ_BYTE: begin
                o_entry.cnt  = 2'd0;
                o_entry.data = {i_write_data[7:0], 24'h000000};
            end
            SZ_HALF: begin
                o_entry.cnt  = 2'd1;
                o_entry.data = {i_write_data[15:0], 16'h0000};
            end
            default: begin
                // word, and the unused size code taken as word
                o_entry.cnt  = 2'd3;
                o_entry.data = i_write_data;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/esar_fifo.sv
`default_nettype none
module esar_fifo #(
    parameter int DEPTH = esar_pkg::FIFO_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  esar_pkg::t_access i_entry,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output esar_pkg::t_access o_entry
);
    import esar_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_access            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

### hdl/esar_rom_mod.sv
`default_nettype none
module esar_rom_mod (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  esar_pkg::t_byte i_byte,
    output logic            o_valid,
    output esar_pkg::t_byte o_byte
);
    import esar_pkg::*;

    // one restoring remainder step per stage, MSB of the dividend first
    localparam int STAGES = ROM_IDX_W;

    t_byte              r_stage [STAGES];
    logic [STAGES-1:0]  r_valid;

    function automatic t_byte div_step(input t_byte b);
        logic [ROM_IDX_W:0] trial;
        t_byte              res;
        res   = b;
        trial = {b.rem, b.dvd[ROM_IDX_W-1]};
        if (trial >= b.rom_size) begin
            trial = trial - b.rom_size;
        end
        res.rem = trial[ROM_IDX_W-1:0];
        res.dvd = {b.dvd[ROM_IDX_W-2:0], 1'b0};
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage[0] <= div_step(i_byte);
            for (int s = 1; s < STAGES; s++) begin
                r_stage[s] <= div_step(r_stage[s-1]);
            end
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_byte  = r_stage[STAGES-1];

endmodule
`default_nettype wire

### hdl/esar_back.sv
`default_nettype none
module esar_back #(
    parameter int NUM_SLOTS = esar_pkg::NUM_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esar_pkg::t_cfg_wr i_cfg,
    input  logic              i_q_valid,
    input  esar_pkg::t_access i_q_entry,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output esar_pkg::t_result o_out
);
    import esar_pkg::*;

    localparam logic [CFG_IDX_W-1:0]  CFG_CARD_MASK     = CFG_IDX_W'(0);
    localparam int                    CFG_ROM_SIZE_BASE = 1;
    localparam logic [ROM_SIZE_W-1:0] ROM_SIZE_MAX      = ROM_SIZE_W'(25'h1000000);

    localparam logic [7:0]  WIN16_LO   = 8'hF9;   // 0xF9000000
    localparam logic [7:0]  WIN16_HI   = 8'hFE;   // up to 0xFEFFFFFF
    localparam logic [3:0]  NIB_LO     = 4'h9;    // 0x00900000 / 0x90000000
    localparam logic [3:0]  NIB_HI     = 4'hE;    // 0x00EFFFFF / 0xEFFFFFFF
    localparam logic [3:0]  FIRST_SLOT = 4'd9;
    localparam logic [19:0] ROM_REGION = 20'hE0000;
    localparam logic [2:0]  NS         = 3'(NUM_SLOTS);

    // configuration
    logic [MAX_SLOTS-1:0]  r_card_mask;
    logic [ROM_SIZE_W-1:0] r_rom_size [NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_mask <= '0;
            for (int j = 0; j < NUM_SLOTS; j++) begin
                r_rom_size[j] <= '0;
            end
        end else if (i_cfg.we) begin
            if (i_cfg.idx == CFG_CARD_MASK) begin
                r_card_mask <= i_cfg.data[MAX_SLOTS-1:0];
            end
            for (int j = 0; j < NUM_SLOTS; j++) begin
                if (i_cfg.idx == CFG_IDX_W'(CFG_ROM_SIZE_BASE + j)) begin
                    r_rom_size[j] <= (i_cfg.data > ROM_SIZE_MAX) ? ROM_SIZE_MAX
                                                                 : i_cfg.data;
                end
            end
        end
    end

    // whole pipeline moves together; stalls only when the output is held
    logic w_en;
    assign w_en = !o_out_valid || i_out_ready;

    // byte sequencer
    logic        r_busy;
    logic        r_wr;
    logic [31:0] r_addr;
    logic [1:0]  r_cnt;
    logic [31:0] r_data;
    logic        w_last_byte;

    assign w_last_byte = (r_cnt == 2'd0);
    assign o_q_pop     = w_en && i_q_valid && (!r_busy || w_last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_en) begin
            if (o_q_pop) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last_byte) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (o_q_pop) begin
                r_wr   <= i_q_entry.wr;
                r_addr <= i_q_entry.addr;
                r_cnt  <= i_q_entry.cnt;
                r_data <= i_q_entry.data;
            end else if (r_busy) begin
                r_addr <= r_addr + 32'd1;
                r_cnt  <= r_cnt - 2'd1;
                r_data <= {r_data[23:0], 8'h00};
            end
        end
    end

    // window decode and routing of the current byte
    logic                  d_mapped;
    logic [2:0]            d_k;
    logic [OFFSET_W-1:0]   d_off;
    logic [7:0]            w_mask_ext;
    logic                  d_present;
    logic                  d_high;
    logic [ROM_SIZE_W-1:0] d_size;
    t_byte                 n_dec;

    assign w_mask_ext = {2'b00, r_card_mask};

    always_comb begin
        d_mapped = 1'b0;
        d_k      = 3'd0;
        d_off    = '0;
        if (r_addr[31:24] >= WIN16_LO && r_addr[31:24] <= WIN16_HI) begin
            d_mapped = 1'b1;
            d_k      = 3'(r_addr[31:24] - WIN16_LO);
            d_off    = {4'h0, r_addr[23:0]};
        end else if (r_addr[31:24] == 8'h00 && r_addr[23:20] >= NIB_LO
                     && r_addr[23:20] <= NIB_HI) begin
            d_mapped = 1'b1;
            d_k      = 3'(r_addr[23:20] - NIB_LO);
            d_off    = {8'h00, r_addr[19:0]};
        end else if (r_addr[31:28] >= NIB_LO && r_addr[31:28] <= NIB_HI) begin
            d_mapped = 1'b1;
            d_k      = 3'(r_addr[31:28] - NIB_LO);
            d_off    = r_addr[27:0];
        end
        // slot past the configured count: same as unmapped
        if (d_mapped && d_k >= NS) begin
            d_mapped = 1'b0;
            d_k      = 3'd0;
            d_off    = '0;
        end
    end

    always_comb begin
        d_size = '0;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if (d_k == 3'(j)) begin
                d_size = r_rom_size[j];
            end
        end
    end

    assign d_present = d_mapped && w_mask_ext[d_k];
    assign d_high    = (d_off[19:0] >= ROM_REGION);

    always_comb begin
        n_dec.slot      = d_mapped ? (4'(d_k) + FIRST_SLOT) : 4'd0;
        n_dec.offset    = d_off;
        n_dec.byte_data = 8'h00;
        n_dec.last      = w_last_byte;
        n_dec.rom_size  = d_size;
        n_dec.dvd       = ~d_off[ROM_IDX_W-1:0];   // 0xFFFFFF - offset
        n_dec.rem       = '0;
        if (!d_present) begin
            n_dec.target = r_wr ? TGT_WRITE_DROP : TGT_OPEN_BUS;
        end else if (r_wr) begin
            if (!d_high) begin
                n_dec.target    = TGT_DEV_WRITE;
                n_dec.byte_data = r_data[31:24];
            end else begin
                n_dec.target = TGT_WRITE_DROP;
            end
        end else if (!d_high || d_size == '0) begin
            n_dec.target = TGT_DEV_READ;
        end else begin
            n_dec.target = TGT_ROM_READ;
        end
    end

    t_byte r_dec;
    logic  r_dec_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else if (w_en) begin
            r_dec_valid <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dec <= n_dec;
        end
    end

    // remainder pipeline for the ROM index
    logic  w_mod_valid;
    t_byte w_mod_byte;

    esar_rom_mod u_rom_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_dec_valid),
        .i_byte  (r_dec),
        .o_valid (w_mod_valid),
        .o_byte  (w_mod_byte)
    );

    // output register
    logic [ROM_SIZE_W-1:0] w_idx_full;
    t_result               n_out;
    t_result               r_out;
    logic                  r_out_valid;

    assign w_idx_full = w_mod_byte.rom_size - ROM_SIZE_W'(1)
                        - {1'b0, w_mod_byte.rem};

    always_comb begin
        n_out.target    = w_mod_byte.target;
        n_out.slot      = w_mod_byte.slot;
        n_out.offset    = w_mod_byte.offset;
        n_out.byte_data = w_mod_byte.byte_data;
        n_out.last      = w_mod_byte.last;
        n_out.rom_index = (w_mod_byte.target == TGT_ROM_READ)
                          ? w_idx_full[ROM_IDX_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_mod_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
`default_nettype wire

### hdl/expansion_slot_access_router.sv
`default_nettype none
// Path: access queue, byte sequencer, decode register, remainder pipeline, output register.
// Throughput: one byte result per cycle while the output is not held; byte 1, halfword 2,
//   word 4 results per access, set by the byte sequencer that walks one address per cycle.
// ROM index comes from a 24-stage remainder pipeline, one quotient bit each.
// Reset: synchronous, active low; empties the queue and pipeline and
//   clears card mask and ROM sizes (no cards, no ROMs).
module expansion_slot_access_router #(
    parameter int NUM_SLOTS  = esar_pkg::NUM_SLOTS_DEF,   // 1..6
    parameter int FIFO_DEPTH = esar_pkg::FIFO_DEPTH_DEF   // 2 or more
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration write port: 0 card mask, 1..6 ROM size of slot 9..14
    input  logic                              i_cfg_we,
    input  logic [esar_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [esar_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,

    // access in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // address[31:0], access_size[33:32],
                                        // write_data[65:34], zero pad
    input  logic [0:0]  s_axis_tuser,   // op: 0 read, 1 write

    // byte results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // slot_number[3:0], slot_offset[31:4],
                                        // rom_index[55:32], byte_data[63:56]
    output logic [2:0]  m_axis_tuser,   // target
    output logic        m_axis_tlast    // last byte of the access
);
    import esar_pkg::*;

    // front: accept the access and work out byte count and byte order
    logic    w_push;
    logic    w_full;
    t_access w_push_entry;

    esar_front u_front (
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_op          (s_axis_tuser[0]),
        .i_address     (s_axis_tdata[31:0]),
        .i_access_size (s_axis_tdata[33:32]),
        .i_write_data  (s_axis_tdata[65:34]),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    // short access queue decouples input transfers from byte output stalls
    logic    w_q_valid;
    logic    w_q_pop;
    t_access w_q_entry;

    esar_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .o_full  (w_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_entry (w_q_entry)
    );

    // back: split into bytes, decode windows, route, compute ROM index
    t_cfg_wr w_cfg;
    t_result w_out;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = i_cfg_addr;
    assign w_cfg.data = i_cfg_wdata;

    esar_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_q_entry),
        .o_q_pop     (w_q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (w_out)
    );

    assign m_axis_tdata = {w_out.byte_data, w_out.rom_index, w_out.offset, w_out.slot};
    assign m_axis_tuser = w_out.target;
    assign m_axis_tlast = w_out.last;

endmodule
`default_nettype wire

### hdl/esar_checker.sv
`default_nettype none
module esar_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import esar_pkg::*;

    // a held result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // ROM reads only from a mapped slot in the top region of a 1 MB block of its offset
    a_rom_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == TGT_ROM_READ
            |-> m_axis_tdata[23:4] >= 20'hE0000 && m_axis_tdata[3:0] != 4'd0)
        else $error("ROM read outside ROM region");

    a_rom_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != TGT_ROM_READ |-> m_axis_tdata[55:32] == 24'd0)
        else $error("ROM index on non-ROM result");

    a_wdata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != TGT_DEV_WRITE |-> m_axis_tdata[63:56] == 8'd0)
        else $error("write byte on non-write result");

endmodule

bind expansion_slot_access_router esar_checker u_esar_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

### tb/esar_tb_pkg.sv
`timescale 1ns / 1ps
package esar_tb_pkg;

    // config write port register map
    typedef enum logic [2:0] {
        REG_CARD_MASK   = 3'd0,
        REG_ROM_SIZE_9  = 3'd1,
        REG_ROM_SIZE_10 = 3'd2,
        REG_ROM_SIZE_11 = 3'd3,
        REG_ROM_SIZE_12 = 3'd4,
        REG_ROM_SIZE_13 = 3'd5,
        REG_ROM_SIZE_14 = 3'd6,
        REG_SPARE       = 3'd7
    } t_cfg_reg;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    // size 3 behaves as a word
    typedef enum logic [1:0] {
        SIZE_BYTE     = 2'd0,
        SIZE_HALF     = 2'd1,
        SIZE_WORD     = 2'd2,
        SIZE_WORD_ALT = 2'd3
    } t_size;

endpackage

### tb/esar_byte_checker.sv
`timescale 1ns / 1ps
module esar_byte_checker #(
    parameter int NUM_SLOTS = esar_pkg::NUM_SLOTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [esar_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [esar_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [71:0]                     s_axis_tdata,   // address, access_size, write_data
    input  logic [0:0]                      s_axis_tuser,   // op
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [63:0]                     m_axis_tdata,   // slot, offset, rom_index, byte
    input  logic [2:0]                      m_axis_tuser,   // target
    input  logic                            m_axis_tlast,
    input  logic                            i_end_check,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_bytes_checked
);
    import esar_pkg::*;
    import esar_tb_pkg::*;

    localparam logic [31:0] SLOT_SPACE_LO = 32'hF900_0000;
    localparam logic [31:0] SLOT_SPACE_HI = 32'hFF00_0000;
    localparam logic [31:0] SLOT24_LO     = 32'h0090_0000;
    localparam logic [31:0] SLOT24_HI     = 32'h00F0_0000;
    localparam logic [31:0] SUPER_LO      = 32'h9000_0000;
    localparam logic [31:0] SUPER_HI      = 32'hF000_0000;
    localparam logic [19:0] ROM_AREA_LO   = 20'hE_0000;
    localparam logic [24:0] ROM_SIZE_MAX  = 25'h100_0000;
    localparam int          FIRST_SLOT    = 9;
    localparam int          MAX_REPORTS   = 40;

    logic [5:0]            card_mask = '0;
    logic [ROM_SIZE_W-1:0] rom_len [MAX_SLOTS] = '{default: '0};
    t_result               expected_bytes [$];
    int                    fails   = 0;
    int                    checked = 0;

    task automatic report_mismatch(string msg);
        fails++;
        if (fails <= MAX_REPORTS)
            $display("[%0t] byte result %0d: %s", $time, checked, msg);
    endtask

    // window decode and routing of one byte address
    function automatic t_result route_byte_access(logic [31:0] a, logic wr, logic [7:0] b,
                                                  logic fin);
        t_result               r;
        logic                  mapped;
        logic                  present;
        int                    slot;
        logic [27:0]           off;
        logic [ROM_SIZE_W-1:0] len;
        logic [23:0]           from_end;
        r      = '0;
        mapped = 1'b1;
        slot   = 0;
        off    = '0;
        if (a >= SLOT_SPACE_LO && a < SLOT_SPACE_HI) begin
            slot = FIRST_SLOT + int'((a - SLOT_SPACE_LO) >> 24);
            off  = {4'd0, a[23:0]};
        end else if (a >= SLOT24_LO && a < SLOT24_HI) begin
            slot = int'(a[23:20]);
            off  = {8'd0, a[19:0]};
        end else if (a >= SUPER_LO && a < SUPER_HI) begin
            slot = FIRST_SLOT + int'((a - SUPER_LO) >> 28);
            off  = a[27:0];
        end else begin
            mapped = 1'b0;
        end
        if (mapped && slot >= FIRST_SLOT + NUM_SLOTS) begin
            mapped = 1'b0;
            slot   = 0;
            off    = '0;
        end
        present  = mapped && card_mask[slot - FIRST_SLOT];
        r.slot   = slot[3:0];
        r.offset = off;
        r.last   = fin;
        if (!present) begin
            if (wr) r.target = TGT_WRITE_DROP;
            else    r.target = TGT_OPEN_BUS;
        end else if (wr) begin
            if (off[19:0] < ROM_AREA_LO) begin
                r.target    = TGT_DEV_WRITE;
                r.byte_data = b;
            end else begin
                r.target = TGT_WRITE_DROP;
            end
        end else begin
            len = rom_len[slot - FIRST_SLOT];
            if (off[19:0] < ROM_AREA_LO || len == '0) begin
                r.target = TGT_DEV_READ;
            end else begin
                if (len > ROM_SIZE_MAX) len = ROM_SIZE_MAX;
                // ROM image is tiled down from offset 0xFFFFFF
                from_end    = 24'((25'h0FF_FFFF - {1'b0, off[23:0]}) % len);
                r.rom_index = 24'(len - 25'd1 - {1'b0, from_end});
                r.target    = TGT_ROM_READ;
            end
        end
        return r;
    endfunction

    // most significant byte goes first, addresses count up
    task automatic queue_access_bytes(logic wr, logic [31:0] addr, logic [1:0] size,
                                      logic [31:0] data);
        int n;
        n = (size == SIZE_BYTE) ? 1 : (size == SIZE_HALF) ? 2 : 4;
        for (int i = 0; i < n; i++)
            expected_bytes.push_back(route_byte_access(addr + 32'(i), wr,
                                     8'(data >> (8 * (n - 1 - i))), i == n - 1));
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            card_mask = '0;
            foreach (rom_len[k]) rom_len[k] = '0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_CARD_MASK)
                    card_mask = i_cfg_wdata[5:0];
                else if (i_cfg_addr <= REG_ROM_SIZE_14)
                    rom_len[i_cfg_addr - REG_ROM_SIZE_9] = i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready)
                queue_access_bytes(s_axis_tuser[0], s_axis_tdata[31:0], s_axis_tdata[33:32],
                                   s_axis_tdata[65:34]);
            if (m_axis_tvalid && m_axis_tready) begin
                got.target    = t_target'(m_axis_tuser);
                got.slot      = m_axis_tdata[3:0];
                got.offset    = m_axis_tdata[31:4];
                got.rom_index = m_axis_tdata[55:32];
                got.byte_data = m_axis_tdata[63:56];
                got.last      = m_axis_tlast;
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer, tdata 0x%h", m_axis_tdata));
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.target !== want.target)
                        report_mismatch($sformatf("target %0d, expected %0d",
                                                  got.target, want.target));
                    if (got.slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, expected %0d",
                                                  got.slot, want.slot));
                    if (got.offset !== want.offset)
                        report_mismatch($sformatf("offset 0x%h, expected 0x%h",
                                                  got.offset, want.offset));
                    if (got.rom_index !== want.rom_index)
                        report_mismatch($sformatf("rom_index 0x%h, expected 0x%h",
                                                  got.rom_index, want.rom_index));
                    if (got.byte_data !== want.byte_data)
                        report_mismatch($sformatf("byte_data 0x%h, expected 0x%h",
                                                  got.byte_data, want.byte_data));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  got.last, want.last));
                end
                checked++;
            end
            if (i_end_check && expected_bytes.size() != 0) begin
                report_mismatch($sformatf("%0d expected bytes never arrived",
                                          expected_bytes.size()));
                expected_bytes.delete();
            end
        end
        o_fail_count    = fails;
        o_pending       = expected_bytes.size();
        o_bytes_checked = checked;
    end

endmodule

### tb/expansion_slot_access_router_tb.sv
`timescale 1ns / 1ps
module expansion_slot_access_router_tb;
    import esar_pkg::*;
    import esar_tb_pkg::*;

    localparam int STALL_LIMIT     = 4000;  // cycles with no transfer at all
    localparam int DRAIN_CYCLES    = 60;    // extra idle time before the end check
    localparam int ITEMS_PER_PHASE = 39;
    localparam int HOLD_OFF_CYCLES = 400;   // long receiver stall, fills the pipe

    // DUT inputs, all known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [71:0]           s_axis_tdata  = '0;  // address, access_size, write_data, pad
    logic [0:0]            s_axis_tuser  = '0;  // op
    logic                  m_axis_tready = 1'b0;

    // DUT outputs
    wire                   s_axis_tready;
    wire                   m_axis_tvalid;
    wire  [63:0]           m_axis_tdata;        // slot, offset, rom_index, byte_data
    wire  [2:0]            m_axis_tuser;        // target
    wire                   m_axis_tlast;

    logic rx_hold   = 1'b0;
    logic end_check = 1'b0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   accesses_sent  = 0;
    int   cfg_writes     = 0;
    int   quiet_cycles   = 0;
    int   fail_count;
    int   pending_bytes;
    int   bytes_checked;

    expansion_slot_access_router DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    esar_byte_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .i_end_check     (end_check),
        .o_fail_count    (fail_count),
        .o_pending       (pending_bytes),
        .o_bytes_checked (bytes_checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver: random stalls per cycle, forced low while a hold-off runs.
    always @(posedge i_clk) begin
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: any transfer (access, byte result or config write) restarts it.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("** expansion_slot_access_router: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One register write; the enable drops for a cycle between writes so the
    // port never sees two assignments in one step.
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // Offer one access and return at the edge where it transfers. Valid is
    // left high so back-to-back accesses need no extra assignment.
    task automatic send_access(t_op op, logic [31:0] addr, t_size size, logic [31:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, data, size, addr};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        accesses_sent++;
    endtask

    // Ends at a falling edge; the checker's counters are stable there.
    task automatic wait_drained();
        do @(negedge i_clk); while (pending_bytes != 0);
    endtask

    task automatic hold_receiver(int cycles);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (cycles) @(posedge i_clk);
        rx_hold <= 1'b0;
    endtask

    // Mostly inside a window: device area, ROM area, or the last few bytes
    // of a slot so that multi-byte accesses cross into the next slot or out
    // of the window. Some just below a window, some anywhere.
    function automatic logic [31:0] pick_address();
        logic [31:0] base;
        logic [31:0] span;
        logic [31:0] off;
        int          k;
        k = $urandom_range(5);
        case ($urandom_range(2))
            0: begin
                base = 32'hF900_0000 + (32'(k) << 24);
                span = 32'h0100_0000;
            end
            1: begin
                base = 32'h0090_0000 + (32'(k) << 20);
                span = 32'h0010_0000;
            end
            default: begin
                base = 32'h9000_0000 + (32'(k) << 28);
                span = 32'h1000_0000;
            end
        endcase
        off = $urandom & (span - 1);
        case ($urandom_range(9))
            0, 1:    return $urandom;
            2:       return base - 32'(k) * span - 32'($urandom_range(1, 3));
            3, 4:    off[19:0] = 20'hE_0000 | 20'($urandom_range(20'h1_FFFF));
            5:       off = span - 32'd1 - 32'($urandom_range(3));
            default: ;
        endcase
        return base + off;
    endfunction

    // No ROM, tiny, random, exactly 16 MB, any 25-bit value, or a power of two
    function automatic logic [CFG_DATA_W-1:0] pick_rom_size();
        case ($urandom_range(5))
            0:       return '0;
            1:       return 25'd1;
            2:       return 25'($urandom_range(1, 4096));
            3:       return 25'h100_0000;
            4:       return 25'($urandom);
            default: return 25'd1 << $urandom_range(23);
        endcase
    endfunction

    task automatic load_random_config();
        logic [5:0] mask;
        mask = ($urandom_range(3) == 0) ? 6'h3F : 6'($urandom);
        // upper bits of the card mask write are junk the block must drop
        write_reg(REG_CARD_MASK, {19'($urandom), mask});
        for (int k = 0; k < MAX_SLOTS; k++)
            write_reg(t_cfg_reg'(int'(REG_ROM_SIZE_9) + k), pick_rom_size());
        if ($urandom_range(1) == 1)
            write_reg(REG_SPARE, 25'($urandom));
    endtask

    // One random phase at given idle rates; optional long receiver hold-off.
    task automatic run_random_phase(int send_pct, int recv_pct, bit with_hold_off);
        wait_drained();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        load_random_config();
        if (with_hold_off)
            fork
                hold_receiver(HOLD_OFF_CYCLES);
            join_none
        repeat (ITEMS_PER_PHASE)
            send_access(t_op'($urandom_range(1)), pick_address(),
                        t_size'($urandom_range(3)), $urandom);
        s_axis_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, no idling. All cards in, ROM sizes chosen for the
        // corner cases: none (falls back to device), 16 MB, one byte,
        // oversized (saturates), odd length, 64 KB.
        write_reg(REG_CARD_MASK,   25'h000_003F);
        write_reg(REG_ROM_SIZE_9,  25'h000_0000);
        write_reg(REG_ROM_SIZE_10, 25'h100_0000);
        write_reg(REG_ROM_SIZE_11, 25'h000_0001);
        write_reg(REG_ROM_SIZE_12, 25'h1FF_FFFF);
        write_reg(REG_ROM_SIZE_13, 25'h000_0123);
        write_reg(REG_ROM_SIZE_14, 25'h001_0000);
        write_reg(REG_SPARE,       25'h1FF_FFFF);   // no such register, ignored

        send_access(OP_READ,  32'hF900_0000, SIZE_WORD,     32'h0000_0000);
        send_access(OP_READ,  32'hF90D_FFFE, SIZE_WORD,     32'h0000_0000);
        send_access(OP_READ,  32'hFAFF_FFFE, SIZE_WORD,     32'hFFFF_FFFF);  // slot 10 -> 11
        send_access(OP_READ,  32'hFB0E_0000, SIZE_HALF,     32'h0000_0000);  // one-byte ROM
        send_access(OP_WRITE, 32'hFEFF_FFFE, SIZE_WORD,     32'hDEAD_BEEF);  // off the window
        send_access(OP_READ,  32'hFFFF_FFFE, SIZE_WORD,     32'h0000_0000);  // 32-bit wrap
        send_access(OP_WRITE, 32'hFFFF_FFFF, SIZE_BYTE,     32'hFFFF_FFFF);
        send_access(OP_READ,  32'h008F_FFFF, SIZE_HALF,     32'h0000_0000);  // into 24-bit space
        send_access(OP_WRITE, 32'h009D_FFFE, SIZE_WORD,     32'h1122_3344);  // device -> drop
        send_access(OP_READ,  32'h00EF_FFFE, SIZE_WORD,     32'h0000_0000);  // out of it
        send_access(OP_WRITE, 32'h00C0_0000, SIZE_HALF,     32'h0000_0000);
        send_access(OP_READ,  32'h8FFF_FFFE, SIZE_WORD,     32'h0000_0000);  // into super space
        send_access(OP_WRITE, 32'h9000_1000, SIZE_WORD,     32'h0123_4567);
        send_access(OP_READ,  32'hBFFF_FFFE, SIZE_WORD,     32'h0000_0000);
        send_access(OP_READ,  32'hCFFF_FFFC, SIZE_WORD,     32'h0000_0000);  // saturated ROM
        send_access(OP_READ,  32'hDFFF_FFFE, SIZE_WORD,     32'h0000_0000);
        send_access(OP_READ,  32'hEFFF_FFFE, SIZE_WORD,     32'h0000_0000);  // out of it
        send_access(OP_WRITE, 32'hC00D_FFFF, SIZE_WORD_ALT, 32'hFFFF_ABCD);  // size 3 = word
        send_access(OP_READ,  32'hF90F_FFFF, SIZE_WORD_ALT, 32'h0000_0000);
        send_access(OP_READ,  32'h0000_0000, SIZE_BYTE,     32'h0000_0000);
        send_access(OP_READ,  32'h00EE_0000, SIZE_WORD,     32'h0000_0000);  // 24-bit ROM area
        send_access(OP_WRITE, 32'hA000_0000, SIZE_WORD,     32'hFFFF_FFFF);
        s_axis_tvalid <= 1'b0;

        // No cards: open bus and dropped writes, decode still shown
        wait_drained();
        write_reg(REG_CARD_MASK, 25'h1FF_FFC0);
        send_access(OP_READ,  32'hF900_0000, SIZE_WORD, 32'h0000_0000);
        send_access(OP_WRITE, 32'h0090_0000, SIZE_WORD, 32'hA5A5_5A5A);
        send_access(OP_READ,  32'h9FFF_FFFF, SIZE_HALF, 32'h0000_0000);
        s_axis_tvalid <= 1'b0;

        // Random part: no idling with a long hold-off, sender idle,
        // receiver stalling, then both.
        run_random_phase(0,  0,  1'b1);
        run_random_phase(75, 0,  1'b0);
        run_random_phase(0,  75, 1'b0);
        run_random_phase(37, 37, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        end_check <= 1'b1;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);

        $display("covered %0d accesses, %0d byte results checked, %0d register writes",
                 accesses_sent, bytes_checked, cfg_writes);
        $display("directed corners, then random traffic under four idle/stall mixes");
        if (fail_count == 0)
            $display("** expansion_slot_access_router: PASSED **");
        else
            $display("** expansion_slot_access_router: FAILED **");
        $finish;
    end

endmodule
